// File: rtl/core/hopscotch_hash_table_core_macros.svh
// Assertion macros shared by the hash table checker.
`ifndef HOPSCOTCH_HASH_TABLE_CORE_MACROS_SVH
`define HOPSCOTCH_HASH_TABLE_CORE_MACROS_SVH

// Generic clocked assertion with an active-low reset.
`define HHT_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Assertion on the block clock and reset.
`define HHT_ASSERT(lbl, prop, msg) \
  `HHT_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// File: rtl/core/hht_pkg.sv
// Package with sizes, codes and helper functions of the hash table.
`default_nettype none
package hht_pkg;

  localparam int unsigned TABLE_LOG2   = 10;
  localparam int unsigned NEIGHBORHOOD = 32;
  localparam int unsigned KEY_BYTES    = 8;
  localparam int unsigned VALUE_BYTES  = 8;

  localparam int unsigned SLOT_COUNT = (1 << TABLE_LOG2) + NEIGHBORHOOD;
  localparam int unsigned SLOT_W     = $clog2(SLOT_COUNT);
  localparam int unsigned OFF_W      = $clog2(NEIGHBORHOOD);
  localparam int unsigned HOOD_W     = NEIGHBORHOOD;

  // Slot word: occupied, key length, value length, key, value.
  localparam int unsigned SLOT_BITS = 1 + 4 + 4 + 64 + 64;
  localparam int unsigned OCC_BIT   = SLOT_BITS - 1;

  typedef enum logic [1:0] {
    ACT_GET        = 2'd0,
    ACT_GET_REMOVE = 2'd1,
    ACT_PUT        = 2'd2,
    ACT_REMOVE     = 2'd3
  } act_e;

  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_CLR,
    CMD_LOAD,
    CMD_RD_HOME_BM,
    CMD_LATCH_BM,
    CMD_RD_CAND,
    CMD_CMP,
    CMD_HIT_WR,
    CMD_RD_FREE,
    CMD_INC_FREE,
    CMD_FULL,
    CMD_INIT_D,
    CMD_RD_ANC,
    CMD_EVAL,
    CMD_RD_FROM,
    CMD_MOVE,
    CMD_CLR_FROM,
    CMD_INS_SLOT,
    CMD_INS_BM,
    CMD_RESULT
  } cmd_e;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BM_RD,
    ST_BM_LATCH,
    ST_SEARCH,
    ST_CMP,
    ST_HIT_WR,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_HOOD_CHK,
    ST_ANC_RD,
    ST_ANC_EVAL,
    ST_FROM_RD,
    ST_MOVE,
    ST_FROM_CLR,
    ST_INS_SLOT,
    ST_INS_BM,
    ST_DONE
  } state_e;

  typedef struct packed {
    act_e act;
    logic clr_last;
    logic bm_zero;
    logic key_match;
    logic slot_occ;
    logic free_last;
    logic in_hood;
    logic anc_ok;
    logic d_last;
    logic out_busy;
  } dp_status_t;

  // Index of the lowest set bit; zero for an empty vector.
  function automatic logic [OFF_W-1:0] low_bit(input logic [HOOD_W-1:0] v);
    logic [OFF_W-1:0] r;
    r = '0;
    for (int i = HOOD_W - 1; i >= 0; i--) begin
      if (v[i]) r = OFF_W'(i);
    end
    return r;
  endfunction

  // Mask that keeps the first n bytes of a 64-bit word.
  function automatic logic [63:0] byte_keep(input logic [3:0] n);
    logic [63:0] m;
    for (int i = 0; i < 8; i++) begin
      m[8*i +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/hht_ctrl.sv
// Controller state machine that sequences lookups, probes and moves.
`default_nettype none
module hht_ctrl
  import hht_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t status_i,
  output cmd_e       cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = CMD_NONE;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o = CMD_CLR;
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o   = CMD_LOAD;
          state_d = ST_BM_RD;
        end
      end
      ST_BM_RD: begin
        cmd_o   = CMD_RD_HOME_BM;
        state_d = ST_BM_LATCH;
      end
      ST_BM_LATCH: begin
        cmd_o   = CMD_LATCH_BM;
        state_d = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (status_i.bm_zero) begin
          state_d = (status_i.act == ACT_PUT) ? ST_FREE_RD : ST_DONE;
        end else begin
          cmd_o   = CMD_RD_CAND;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o = CMD_CMP;
        if (status_i.key_match) begin
          state_d = (status_i.act == ACT_GET) ? ST_DONE : ST_HIT_WR;
        end else begin
          state_d = ST_SEARCH;
        end
      end
      ST_HIT_WR: begin
        cmd_o   = CMD_HIT_WR;
        state_d = ST_DONE;
      end
      ST_FREE_RD: begin
        cmd_o   = CMD_RD_FREE;
        state_d = ST_FREE_CHK;
      end
      ST_FREE_CHK: begin
        priority if (!status_i.slot_occ) begin
          state_d = ST_HOOD_CHK;
        end else if (status_i.free_last) begin
          cmd_o   = CMD_FULL;
          state_d = ST_DONE;
        end else begin
          cmd_o   = CMD_INC_FREE;
          state_d = ST_FREE_RD;
        end
      end
      ST_HOOD_CHK: begin
        if (status_i.in_hood) begin
          state_d = ST_INS_SLOT;
        end else begin
          cmd_o   = CMD_INIT_D;
          state_d = ST_ANC_RD;
        end
      end
      ST_ANC_RD: begin
        cmd_o   = CMD_RD_ANC;
        state_d = ST_ANC_EVAL;
      end
      ST_ANC_EVAL: begin
        priority if (status_i.anc_ok) begin
          cmd_o   = CMD_EVAL;
          state_d = ST_FROM_RD;
        end else if (status_i.d_last) begin
          cmd_o   = CMD_FULL;
          state_d = ST_DONE;
        end else begin
          cmd_o   = CMD_EVAL;
          state_d = ST_ANC_RD;
        end
      end
      ST_FROM_RD: begin
        cmd_o   = CMD_RD_FROM;
        state_d = ST_MOVE;
      end
      ST_MOVE: begin
        cmd_o   = CMD_MOVE;
        state_d = ST_FROM_CLR;
      end
      ST_FROM_CLR: begin
        cmd_o   = CMD_CLR_FROM;
        state_d = ST_HOOD_CHK;
      end
      ST_INS_SLOT: begin
        cmd_o   = CMD_INS_SLOT;
        state_d = ST_INS_BM;
      end
      ST_INS_BM: begin
        cmd_o   = CMD_INS_BM;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          cmd_o   = CMD_RESULT;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/core/hht_dp.sv
// Datapath: slot and bitmap memories, request registers and result register.
`default_nettype none
module hht_dp
  import hht_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  cmd_e         cmd_i,
  output dp_status_t   status_o,
  input  logic [1:0]   in_action_i,
  input  logic [31:0]  in_key_hash_i,
  input  logic [3:0]   in_key_len_i,
  input  logic [63:0]  in_key_bytes_i,
  input  logic [3:0]   in_value_len_i,
  input  logic [63:0]  in_value_bytes_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic         out_found_o,
  output logic [3:0]   out_value_len_o,
  output logic [63:0]  out_value_o,
  output logic         out_table_full_o
);

  logic [SLOT_BITS-1:0] slot_mem [SLOT_COUNT];
  logic [HOOD_W-1:0]    bm_mem   [SLOT_COUNT];

  logic [SLOT_BITS-1:0] slot_rdata_q;
  logic [HOOD_W-1:0]    bm_rdata_q;

  // Request registers.
  act_e        act_q;
  logic [SLOT_W-1:0] home_q;
  logic [3:0]  klen_q, vlen_q;
  logic [63:0] key_q, val_q;

  // Walk registers.
  logic [SLOT_W-1:0] clr_q, free_q, anchor_q, from_q, cand_q;
  logic [HOOD_W-1:0] bm_q, bm_home_q;
  logic [OFF_W-1:0]  off_q, d_q, move_d_q;
  logic              hit_q, full_q;
  logic [3:0]        hit_vlen_q;
  logic [63:0]       hit_val_q;
  logic              out_valid_q;

  logic [3:0]        klen_sat, vlen_sat;
  logic [OFF_W-1:0]  cand_off, anc_off;
  logic [SLOT_W-1:0] anchor_d, from_d, free_dist;
  logic              match;

  // Memory port controls.
  logic                 slot_we, slot_re, bm_we, bm_re;
  logic [SLOT_W-1:0]    slot_waddr, slot_raddr, bm_waddr, bm_raddr;
  logic [SLOT_BITS-1:0] slot_wdata;
  logic [HOOD_W-1:0]    bm_wdata;

  assign klen_sat = (in_key_len_i > 4'(KEY_BYTES)) ? 4'(KEY_BYTES) : in_key_len_i;
  assign vlen_sat = (in_value_len_i > 4'(VALUE_BYTES)) ? 4'(VALUE_BYTES) : in_value_len_i;

  assign cand_off  = low_bit(bm_q);
  assign anc_off   = low_bit(bm_rdata_q);
  assign anchor_d  = free_q - SLOT_W'(d_q);
  assign from_d    = anchor_q + SLOT_W'(anc_off);
  assign free_dist = free_q - home_q;

  assign match = slot_rdata_q[OCC_BIT] && (slot_rdata_q[OCC_BIT-1 -: 4] == klen_q) &&
                 (slot_rdata_q[127:64] == key_q);

  always_comb begin
    status_o.act       = act_q;
    status_o.clr_last  = (clr_q == SLOT_W'(SLOT_COUNT - 1));
    status_o.bm_zero   = (bm_q == '0);
    status_o.key_match = match;
    status_o.slot_occ  = slot_rdata_q[OCC_BIT];
    status_o.free_last = (free_q == SLOT_W'(SLOT_COUNT - 1));
    status_o.in_hood   = (free_dist < SLOT_W'(NEIGHBORHOOD));
    status_o.anc_ok    = (bm_rdata_q != '0) && (from_d < free_q);
    status_o.d_last    = (d_q == OFF_W'(1));
    status_o.out_busy  = out_valid_q && !out_ready_i;
  end

  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = free_q;
    slot_wdata = '0;
    slot_re    = 1'b0;
    slot_raddr = free_q;
    bm_we      = 1'b0;
    bm_waddr   = home_q;
    bm_wdata   = '0;
    bm_re      = 1'b0;
    bm_raddr   = home_q;
    unique case (cmd_i)
      CMD_CLR: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        bm_we      = 1'b1;
        bm_waddr   = clr_q;
      end
      CMD_RD_HOME_BM: bm_re = 1'b1;
      CMD_RD_CAND: begin
        slot_re    = 1'b1;
        slot_raddr = home_q + SLOT_W'(cand_off);
      end
      CMD_HIT_WR: begin
        slot_we    = 1'b1;
        slot_waddr = cand_q;
        if (act_q == ACT_PUT) begin
          slot_wdata = {1'b1, klen_q, vlen_q, key_q, val_q};
        end else begin
          bm_we    = 1'b1;
          bm_wdata = bm_home_q & ~(HOOD_W'(1) << off_q);
        end
      end
      CMD_RD_FREE: slot_re = 1'b1;
      CMD_RD_ANC: begin
        bm_re    = 1'b1;
        bm_raddr = anchor_d;
      end
      CMD_RD_FROM: begin
        slot_re    = 1'b1;
        slot_raddr = from_q;
      end
      CMD_MOVE: begin
        slot_we    = 1'b1;
        slot_wdata = slot_rdata_q;
        bm_we      = 1'b1;
        bm_waddr   = anchor_q;
        bm_wdata   = (bm_q | (HOOD_W'(1) << move_d_q)) & ~(HOOD_W'(1) << off_q);
      end
      CMD_CLR_FROM: begin
        slot_we    = 1'b1;
        slot_waddr = from_q;
      end
      CMD_INS_SLOT: begin
        slot_we    = 1'b1;
        slot_wdata = {1'b1, klen_q, vlen_q, key_q, val_q};
        bm_re      = 1'b1;
      end
      CMD_INS_BM: begin
        bm_we    = 1'b1;
        bm_wdata = bm_rdata_q | (HOOD_W'(1) << free_dist[OFF_W-1:0]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rdata_q <= slot_mem[slot_raddr];
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    if (bm_re) bm_rdata_q <= bm_mem[bm_raddr];
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i)
      CMD_LOAD: begin
        act_q  <= act_e'(in_action_i);
        home_q <= SLOT_W'(in_key_hash_i[TABLE_LOG2-1:0]);
        free_q <= SLOT_W'(in_key_hash_i[TABLE_LOG2-1:0]);
        klen_q <= klen_sat;
        vlen_q <= vlen_sat;
        key_q  <= in_key_bytes_i & byte_keep(klen_sat);
        val_q  <= in_value_bytes_i & byte_keep(vlen_sat);
      end
      CMD_LATCH_BM: begin
        bm_q      <= bm_rdata_q;
        bm_home_q <= bm_rdata_q;
      end
      CMD_RD_CAND: begin
        off_q  <= cand_off;
        cand_q <= home_q + SLOT_W'(cand_off);
      end
      CMD_CMP: begin
        bm_q       <= bm_q & ~(HOOD_W'(1) << off_q);
        hit_vlen_q <= slot_rdata_q[OCC_BIT-5 -: 4];
        hit_val_q  <= slot_rdata_q[63:0];
      end
      CMD_INC_FREE: free_q <= free_q + SLOT_W'(1);
      CMD_INIT_D:   d_q <= OFF_W'(NEIGHBORHOOD - 1);
      CMD_RD_ANC:   anchor_q <= anchor_d;
      CMD_EVAL: begin
        bm_q     <= bm_rdata_q;
        off_q    <= anc_off;
        from_q   <= from_d;
        move_d_q <= d_q;
        d_q      <= d_q - OFF_W'(1);
      end
      CMD_CLR_FROM: free_q <= from_q;
      CMD_RESULT: begin
        out_found_o      <= hit_q;
        out_table_full_o <= full_q;
        if (hit_q && (act_q == ACT_GET || act_q == ACT_GET_REMOVE)) begin
          out_value_len_o <= hit_vlen_q;
          out_value_o     <= hit_val_q;
        end else begin
          out_value_len_o <= '0;
          out_value_o     <= '0;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      hit_q       <= 1'b0;
      full_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i == CMD_CLR) clr_q <= clr_q + SLOT_W'(1);
      if (cmd_i == CMD_LOAD) begin
        hit_q  <= 1'b0;
        full_q <= 1'b0;
      end
      if (cmd_i == CMD_CMP && match) hit_q <= 1'b1;
      if (cmd_i == CMD_FULL) full_q <= 1'b1;
      if (cmd_i == CMD_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

// File: rtl/core/hopscotch_hash_table_core.sv
// Top level of the hopscotch hash table: controller plus datapath.
//
// Channel   Dir  Word
// s_axis    in   tuser = action; tdata = hash, key length, key, value length, value
// m_axis    out  tdata = found, value length, value, table full
//
// A request loads, reads and latches the home bitmap and compares each neighborhood
// candidate that it marks; a hit that writes adds a slot write. A put miss probes
// slots for a free one, tries anchors, moves entries and then places the key.
// After reset a clearing pass writes all 1056 slots before the first word is taken.
// A result waits in the output register; the next word is taken while it waits.
`default_nettype none
module hopscotch_hash_table_core
  import hht_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [1:0]   s_axis_tuser,  // action
  // key_hash[31:0], key_len[35:32], key_bytes[99:36], value_len[103:100],
  // value_bytes[167:104]
  input  logic [167:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // found[0], out_value_len[4:1], out_value[68:5], table_full[69], zero[71:70]
  output logic [71:0]  m_axis_tdata
);

  dp_status_t status;
  cmd_e       cmd;
  logic       found, table_full;
  logic [3:0] value_len;
  logic [63:0] value;

  hht_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  hht_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .in_action_i      (s_axis_tuser),
    .in_key_hash_i    (s_axis_tdata[31:0]),
    .in_key_len_i     (s_axis_tdata[35:32]),
    .in_key_bytes_i   (s_axis_tdata[99:36]),
    .in_value_len_i   (s_axis_tdata[103:100]),
    .in_value_bytes_i (s_axis_tdata[167:104]),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .out_found_o      (found),
    .out_value_len_o  (value_len),
    .out_value_o      (value),
    .out_table_full_o (table_full)
  );

  assign m_axis_tdata = {2'b00, table_full, value, value_len, found};

endmodule
`default_nettype wire

// File: rtl/core/hht_checker.sv
// Port-level checker for the hash table core and its bind.
`default_nettype none
`include "hopscotch_hash_table_core_macros.svh"
module hht_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [71:0]  m_axis_tdata
);

  // A stalled result word stays offered.
  `HHT_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "result dropped")

  // A request that found its key never reports a full table.
  `HHT_ASSERT(a_full_excl, m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[69]), "found and full")

  // Value data only comes with a hit.
  `HHT_ASSERT(a_miss_empty, m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[68:1] == '0, "miss with value")

  // A returned value length never exceeds the value width.
  `HHT_ASSERT(a_len_range, m_axis_tvalid |-> m_axis_tdata[4:1] <= 4'd8, "value length too large")

  // The input side is closed in the cycle after it takes a word.
  `HHT_ASSERT(a_in_gap, s_axis_tvalid && s_axis_tready |=> !s_axis_tready, "back-to-back accept")

endmodule

bind hopscotch_hash_table_core hht_checker u_hht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
